### sv/gzhp_pkg.sv
// ----------------------------------------------------------------------------
// gzhp_pkg
// shared types and constants for the gzip member header parser
// ----------------------------------------------------------------------------
`default_nettype none

package gzhp_pkg;

  localparam logic [7:0] MAGIC_ID1   = 8'h1f;
  localparam logic [7:0] MAGIC_ID2   = 8'h8b;
  localparam logic [7:0] CM_DEFLATE  = 8'h08;

  localparam logic [7:0] FLG_HCRC    = 8'h02;
  localparam logic [7:0] FLG_EXTRA   = 8'h04;
  localparam logic [7:0] FLG_NAME    = 8'h08;
  localparam logic [7:0] FLG_COMMENT = 8'h10;
  localparam logic [7:0] FLG_RESV    = 8'he0;

  localparam logic [15:0] FIXED_LEN  = 16'd6;
  localparam logic [15:0] HCRC_LEN   = 16'd2;

  localparam logic [1:0] ST_HEADER   = 2'd0;
  localparam logic [1:0] ST_DEFLATE  = 2'd1;
  localparam logic [1:0] ST_PLAIN    = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  // result queue depth and the free room one beat may need
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);
  localparam int unsigned MAX_RES    = 2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [1:0] stream_status;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

### sv/gzhp_parser.sv
// ----------------------------------------------------------------------------
// gzhp_parser
// header state machine: one registered byte in, up to two results out
// ----------------------------------------------------------------------------
`default_nettype none

module gzhp_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire logic [7:0]    data_byte,
  input  wire logic          new_stream,
  output gzhp_pkg::push_t    push
);
  import gzhp_pkg::*;

  typedef enum logic [13:0] {
    PH_MAGIC1  = 14'b00000000000001,
    PH_MAGIC2  = 14'b00000000000010,
    PH_METHOD  = 14'b00000000000100,
    PH_FLAGS   = 14'b00000000001000,
    PH_FIXED   = 14'b00000000010000,
    PH_XLEN_LO = 14'b00000000100000,
    PH_XLEN_HI = 14'b00000001000000,
    PH_EXTRA   = 14'b00000010000000,
    PH_NAME    = 14'b00000100000000,
    PH_COMMENT = 14'b00001000000000,
    PH_HCRC    = 14'b00010000000000,
    PH_PAYLOAD = 14'b00100000000000,
    PH_PLAIN   = 14'b01000000000000,
    PH_ERROR   = 14'b10000000000000
  } phase_t;

  localparam logic [1:0] FROM_EXTRA   = 2'd0;
  localparam logic [1:0] FROM_NAME    = 2'd1;
  localparam logic [1:0] FROM_COMMENT = 2'd2;
  localparam logic [1:0] FROM_HCRC    = 2'd3;

  function automatic phase_t next_part(input logic [1:0] from, input logic [7:0] flg);
    phase_t ph;
    ph = PH_PAYLOAD;
    if (from == FROM_EXTRA && (flg & FLG_EXTRA) != 8'h00) begin
      ph = PH_XLEN_LO;
    end else if (from <= FROM_NAME && (flg & FLG_NAME) != 8'h00) begin
      ph = PH_NAME;
    end else if (from <= FROM_COMMENT && (flg & FLG_COMMENT) != 8'h00) begin
      ph = PH_COMMENT;
    end else if ((flg & FLG_HCRC) != 8'h00) begin
      ph = PH_HCRC;
    end
    return ph;
  endfunction

  function automatic result_t mk_res(input logic [7:0] b, input logic v,
                                     input logic [1:0] st, input logic last);
    result_t r;
    r.out_byte      = b;
    r.out_valid     = v;
    r.stream_status = st;
    r.last_of_run   = last;
    return r;
  endfunction

  phase_t      phase, phase_next, ph_eff, ph_part;
  logic [7:0]  held_byte, held_byte_next, hb_eff;
  logic [7:0]  header_flags, header_flags_next, flg_eff;
  logic [15:0] skip_count, skip_count_next, skip_eff, skip_dec, xlen;
  logic [7:0]  extra_length_low, extra_length_low_next, xlo_eff;
  logic [1:0]  part_from;
  logic        part_go;
  push_t       step;

  // restart takes the reset view of the state for this beat
  always_comb begin
    ph_eff   = new_stream ? PH_MAGIC1 : phase;
    hb_eff   = new_stream ? 8'h00 : held_byte;
    flg_eff  = new_stream ? 8'h00 : header_flags;
    skip_eff = new_stream ? 16'h0000 : skip_count;
    xlo_eff  = new_stream ? 8'h00 : extra_length_low;
  end

  assign skip_dec = (skip_eff == 16'h0000) ? 16'h0000 : skip_eff - 16'd1;
  assign xlen     = {data_byte, xlo_eff};

  always_comb begin
    phase_next            = ph_eff;
    held_byte_next        = hb_eff;
    header_flags_next     = flg_eff;
    skip_count_next       = skip_eff;
    extra_length_low_next = xlo_eff;
    part_from             = FROM_HCRC;
    part_go               = 1'b0;
    step.n                = 2'd1;
    step.r0               = mk_res(8'h00, 1'b0, ST_HEADER, 1'b1);
    step.r1               = mk_res(8'h00, 1'b0, ST_HEADER, 1'b1);
    case (ph_eff)
      PH_MAGIC1: begin
        held_byte_next = data_byte;
        phase_next     = PH_MAGIC2;
      end
      PH_MAGIC2: begin
        if (hb_eff != MAGIC_ID1 || data_byte != MAGIC_ID2) begin
          phase_next = PH_PLAIN;
          step.n     = 2'd2;
          step.r0    = mk_res(hb_eff, 1'b1, ST_PLAIN, 1'b0);
          step.r1    = mk_res(data_byte, 1'b1, ST_PLAIN, 1'b1);
        end else begin
          phase_next = PH_METHOD;
        end
      end
      PH_METHOD: begin
        held_byte_next = data_byte;
        phase_next     = PH_FLAGS;
      end
      PH_FLAGS: begin
        if (hb_eff != CM_DEFLATE || (data_byte & FLG_RESV) != 8'h00) begin
          phase_next = PH_ERROR;
          step.r0    = mk_res(8'h00, 1'b0, ST_BAD, 1'b1);
        end else begin
          header_flags_next = data_byte;
          skip_count_next   = FIXED_LEN;
          phase_next        = PH_FIXED;
        end
      end
      PH_FIXED, PH_EXTRA, PH_HCRC: begin
        skip_count_next = skip_dec;
        if (skip_dec == 16'h0000) begin
          part_go = 1'b1;
          case (ph_eff)
            PH_FIXED: part_from = FROM_EXTRA;
            PH_EXTRA: part_from = FROM_NAME;
            default:  part_from = FROM_HCRC;
          endcase
          if (ph_eff == PH_HCRC) begin
            part_go    = 1'b0;
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_XLEN_LO: begin
        extra_length_low_next = data_byte;
        phase_next            = PH_XLEN_HI;
      end
      PH_XLEN_HI: begin
        skip_count_next = xlen;
        if (xlen == 16'h0000) begin
          part_go   = 1'b1;
          part_from = FROM_NAME;
        end else begin
          phase_next = PH_EXTRA;
        end
      end
      PH_NAME, PH_COMMENT: begin
        if (data_byte == 8'h00) begin
          part_go   = 1'b1;
          part_from = (ph_eff == PH_NAME) ? FROM_COMMENT : FROM_HCRC;
        end
      end
      PH_PAYLOAD: begin
        step.r0 = mk_res(data_byte, 1'b1, ST_DEFLATE, 1'b1);
      end
      PH_PLAIN: begin
        step.r0 = mk_res(data_byte, 1'b1, ST_PLAIN, 1'b1);
      end
      default: begin
        phase_next = PH_ERROR;
        step.r0    = mk_res(8'h00, 1'b0, ST_BAD, 1'b1);
      end
    endcase
    ph_part = next_part(part_from, flg_eff);
    if (part_go) begin
      phase_next = ph_part;
      if (ph_part == PH_HCRC) begin
        skip_count_next = HCRC_LEN;
      end
    end
  end

  always_comb begin
    push   = step;
    push.n = fire ? step.n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_MAGIC1;
      held_byte        <= 8'h00;
      header_flags     <= 8'h00;
      skip_count       <= 16'h0000;
      extra_length_low <= 8'h00;
    end else if (fire) begin
      phase            <= phase_next;
      held_byte        <= held_byte_next;
      header_flags     <= header_flags_next;
      skip_count       <= skip_count_next;
      extra_length_low <= extra_length_low_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> !push.r0.last_of_run && push.r1.last_of_run)
    else $error("two-result beat with wrong run marking");

  a_fire_yields: assert property (@(posedge clk) disable iff (rst)
    fire |-> push.n != 2'd0)
    else $error("accepted byte produced no result");
`endif

endmodule

`default_nettype wire

### sv/gzhp_res_fifo.sv
// ----------------------------------------------------------------------------
// gzhp_res_fifo
// small result queue taking up to two results per cycle, one out per beat
// ----------------------------------------------------------------------------
`default_nettype none

module gzhp_res_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  gzhp_pkg::push_t   push,
  output logic              room,
  output logic              result_valid,
  input  wire logic         result_ready,
  output gzhp_pkg::result_t head
);
  import gzhp_pkg::*;

  result_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;
  logic              pop;

  assign result_valid = (count != '0);
  assign pop          = result_valid && result_ready;
  assign room         = (count <= QCNT_W'(QDEPTH - MAX_RES));
  assign head         = mem[rd_ptr];
  assign count_next   = count + QCNT_W'(push.n) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> count + QCNT_W'(push.n) <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + QCNT_W'($past(push.n)) - QCNT_W'($past(pop)))
    else $error("result queue count out of step");
`endif

endmodule

`default_nettype wire

### sv/gzip_header_parser.sv
// ----------------------------------------------------------------------------
// gzip_header_parser
// strips a gzip member header from a byte stream
// ----------------------------------------------------------------------------
// input channel: byte_valid/byte_ready carry data_byte and new_stream, one
// byte per beat; new_stream restarts parsing with that byte as first magic.
// result channel: result_valid/result_ready carry out_byte, out_valid,
// stream_status and last_of_run. every byte gives one result, except the
// byte that shows the stream is not gzip, which gives two (the held first
// byte, then itself); last_of_run marks the final result of each byte.
// a taken byte waits in the input register until the queue has room; its
// results then go to the result queue. throughput: one byte per cycle while the
// queue has room; the four-entry queue absorbs the two-result byte's extra.
// input is registered, and the parser fires whenever the queue has room for
// two results, so byte_ready does not depend on result_ready.
// reset: parser returns to expecting the first magic byte, queue empties.
// on a result stall the queue fills and byte_ready drops after a few bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module gzip_header_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       new_stream,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic [1:0]      stream_status,
  output logic            last_of_run
);
  import gzhp_pkg::*;

  logic       inr_valid;
  logic [7:0] inr_byte;
  logic       inr_new;
  logic       room;
  logic       fire;
  push_t      push;
  result_t    head;

  assign fire       = inr_valid && room;
  assign byte_ready = !inr_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      inr_valid <= 1'b0;
    end else if (byte_ready) begin
      inr_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      inr_byte <= data_byte;
      inr_new  <= new_stream;
    end
  end

  gzhp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .data_byte  (inr_byte),
    .new_stream (inr_new),
    .push       (push)
  );

  gzhp_res_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .head         (head)
  );

  assign out_byte      = head.out_byte;
  assign out_valid     = head.out_valid;
  assign stream_status = head.stream_status;
  assign last_of_run   = head.last_of_run;

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// gzip header parser: byte stream in, forwarded bytes and header status out.
// a scoreboard class predicts the result beats of every accepted byte from
// its own copy of the header state and checks each result beat in order.
// directed streams come first, then random members: well-formed headers with
// random optional parts, truncated headers, plain streams, bad method or
// flags and noise, with random idling on both sides and one long result hold.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import gzhp_pkg::*;

  typedef enum logic [3:0] {
    P_MAGIC1, P_MAGIC2, P_METHOD, P_FLAGS, P_FIXED, P_XLEN_LO, P_XLEN_HI,
    P_EXTRA, P_NAME, P_COMMENT, P_HCRC, P_PAYLOAD, P_PLAIN, P_ERROR
  } phase_t;

  localparam int ITEM_TARGET = 1950;
  localparam int CALM_ITEMS  = 250;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_LIMIT = 20000;

  class gzip_scoreboard;
    phase_t     phase;
    logic [7:0] held;
    logic [7:0] flags;
    logic [15:0] skip;
    logic [7:0] xlen_lo;
    result_t    pending_results[$];
    int         errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      phase   = P_MAGIC1;
      held    = '0;
      flags   = '0;
      skip    = '0;
      xlen_lo = '0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void add(logic [7:0] b, logic v, logic [1:0] st, logic l);
      result_t r;
      r.out_byte      = b;
      r.out_valid     = v;
      r.stream_status = st;
      r.last_of_run   = l;
      pending_results.push_back(r);
    endfunction

    function phase_t next_part(phase_t from);
      if (from <= P_XLEN_LO && (flags & FLG_EXTRA) != 0) return P_XLEN_LO;
      if (from <= P_NAME && (flags & FLG_NAME) != 0) return P_NAME;
      if (from <= P_COMMENT && (flags & FLG_COMMENT) != 0) return P_COMMENT;
      if (from <= P_HCRC && (flags & FLG_HCRC) != 0) begin
        skip = HCRC_LEN;
        return P_HCRC;
      end
      return P_PAYLOAD;
    endfunction

    function void take_byte(logic [7:0] b, logic ns);
      if (ns) clear();
      case (phase)
        P_MAGIC1: begin
          held  = b;
          phase = P_MAGIC2;
        end
        P_MAGIC2: begin
          if (held != MAGIC_ID1 || b != MAGIC_ID2) begin
            phase = P_PLAIN;
            add(held, 1'b1, ST_PLAIN, 1'b0);
            add(b, 1'b1, ST_PLAIN, 1'b1);
            return;
          end
          phase = P_METHOD;
        end
        P_METHOD: begin
          held  = b;
          phase = P_FLAGS;
        end
        P_FLAGS: begin
          if (held != CM_DEFLATE || (b & FLG_RESV) != 0) begin
            phase = P_ERROR;
            add(8'h00, 1'b0, ST_BAD, 1'b1);
            return;
          end
          flags = b;
          skip  = FIXED_LEN;
          phase = P_FIXED;
        end
        P_FIXED, P_EXTRA, P_HCRC: begin
          if (skip != 0) skip--;
          if (skip == 0)
            phase = next_part(phase == P_FIXED ? P_XLEN_LO :
                              (phase == P_EXTRA ? P_NAME : P_PAYLOAD));
        end
        P_XLEN_LO: begin
          xlen_lo = b;
          phase   = P_XLEN_HI;
        end
        P_XLEN_HI: begin
          skip  = {b, xlen_lo};
          phase = (skip == 0) ? next_part(P_NAME) : P_EXTRA;
        end
        P_NAME, P_COMMENT: begin
          if (b == 8'h00) phase = next_part(phase == P_NAME ? P_COMMENT : P_HCRC);
        end
        P_PAYLOAD: begin
          add(b, 1'b1, ST_DEFLATE, 1'b1);
          return;
        end
        P_PLAIN: begin
          add(b, 1'b1, ST_PLAIN, 1'b1);
          return;
        end
        default: begin
          phase = P_ERROR;
          add(8'h00, 1'b0, ST_BAD, 1'b1);
          return;
        end
      endcase
      add(8'h00, 1'b0, ST_HEADER, 1'b1);
    endfunction

    function void mismatch(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      $error("%s: expected %0h, got %0h", field, want, got);
    endfunction

    function void check_result(logic [7:0] b, logic v, logic [1:0] st, logic l);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $error("result beat with no byte behind it: out_byte %0h", b);
        return;
      end
      want = pending_results.pop_front();
      if (b !== want.out_byte) mismatch("out_byte", want.out_byte, b);
      if (v !== want.out_valid) mismatch("out_valid", want.out_valid, v);
      if (st !== want.stream_status) mismatch("stream_status", want.stream_status, st);
      if (l !== want.last_of_run) mismatch("last_of_run", want.last_of_run, l);
    endfunction

    function void check_drained();
      if (pending_results.size() != 0) begin
        errors++;
        $error("%0d result beats never arrived", pending_results.size());
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       byte_valid;
  logic       byte_ready;
  logic [7:0] data_byte;
  logic       new_stream;
  logic       result_valid;
  logic       result_ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [1:0] stream_status;
  logic       last_of_run;

  gzip_scoreboard sb = new();
  int  items_sent = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;

  gzip_header_parser dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .data_byte     (data_byte),
    .new_stream    (new_stream),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .out_byte      (out_byte),
    .out_valid     (out_valid),
    .stream_status (stream_status),
    .last_of_run   (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && byte_ready) sb.take_byte(data_byte, new_stream);
      if (result_valid && result_ready)
        sb.check_result(out_byte, out_valid, stream_status, last_of_run);
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    result_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ns);
    int gap;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 10);
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    new_stream <= ns;
    do @(posedge clk); while (!byte_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_list(input logic [7:0] q[$], input logic first_ns);
    foreach (q[i]) send_byte(q[i], (i == 0) ? first_ns : 1'b0);
  endtask

  task automatic send_member();
    logic [7:0] q[$];
    int kind;
    int n;
    int xlen;
    logic [7:0] flg;
    logic [7:0] b0;
    logic [7:0] b1;
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      flg = 8'($urandom_range(0, 31));
      q = '{MAGIC_ID1, MAGIC_ID2, CM_DEFLATE, flg};
      repeat (6) q.push_back(8'($urandom_range(0, 255)));
      if ((flg & FLG_EXTRA) != 0) begin
        if ($urandom_range(0, 5) == 0) xlen = 0;
        else if ($urandom_range(0, 30) == 0) xlen = $urandom_range(256, 300);
        else xlen = $urandom_range(1, 24);
        q.push_back(8'(xlen));
        q.push_back(8'(xlen >> 8));
        repeat (xlen) q.push_back(8'($urandom_range(0, 255)));
      end
      if ((flg & FLG_NAME) != 0) begin
        repeat ($urandom_range(0, 6)) q.push_back(8'($urandom_range(1, 255)));
        q.push_back(8'h00);
      end
      if ((flg & FLG_COMMENT) != 0) begin
        repeat ($urandom_range(0, 6)) q.push_back(8'($urandom_range(1, 255)));
        q.push_back(8'h00);
      end
      if ((flg & FLG_HCRC) != 0) repeat (2) q.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 24)) q.push_back(8'($urandom_range(0, 255)));
      // member cut short at a random point, possibly inside the header
      if (kind >= 64) q = q[0:$urandom_range(0, q.size() - 1)];
      send_list(q, 1'b1);
    end else if (kind < 82) begin
      b0 = 8'($urandom_range(0, 255));
      b1 = 8'($urandom_range(0, 255));
      n  = $urandom_range(0, 2);
      if (n == 0) b0 = MAGIC_ID1;
      if (n == 1) b1 = MAGIC_ID2;
      if (b0 == MAGIC_ID1 && b1 == MAGIC_ID2) begin
        if (n == 0) b1 = ~MAGIC_ID2;
        else b0 = ~MAGIC_ID1;
      end
      q = '{b0, b1};
      repeat ($urandom_range(0, 16)) q.push_back(8'($urandom_range(0, 255)));
      send_list(q, 1'b1);
    end else if (kind < 92) begin
      if ($urandom_range(0, 1) == 0) begin
        b0 = 8'($urandom_range(0, 255));
        if (b0 == CM_DEFLATE) b0 = ~CM_DEFLATE;
        flg = 8'($urandom_range(0, 255));
      end else begin
        b0  = CM_DEFLATE;
        flg = {3'($urandom_range(1, 7)), 5'($urandom_range(0, 31))};
      end
      q = '{MAGIC_ID1, MAGIC_ID2, b0, flg};
      repeat ($urandom_range(0, 10)) q.push_back(8'($urandom_range(0, 255)));
      send_list(q, 1'b1);
    end else begin
      repeat ($urandom_range(1, 20))
        send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
    end
  endtask

  initial begin
    logic [7:0] q[$];
    int waited;
    rst        = 1'b1;
    byte_valid = 1'b0;
    data_byte  = '0;
    new_stream = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // gzip with an empty extra field, straight after reset
    q = '{MAGIC_ID1, MAGIC_ID2, CM_DEFLATE, FLG_EXTRA,
          8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff};
    send_list(q, 1'b0);
    // plain stream: held first byte and this one, then passthrough
    q = '{MAGIC_ID1, 8'h00, 8'hff};
    send_list(q, 1'b1);
    // bad method, then bad reserved flags
    q = '{MAGIC_ID1, MAGIC_ID2, 8'h07, 8'h00};
    send_list(q, 1'b1);
    q = '{MAGIC_ID1, MAGIC_ID2, CM_DEFLATE, 8'h80};
    send_list(q, 1'b1);

    hold_req = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      idle_on = (items_sent < ITEM_TARGET - CALM_ITEMS);
      send_member();
    end
    byte_valid <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    sb.check_drained();
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
sv/gzhp_pkg.sv
sv/gzhp_parser.sv
sv/gzhp_res_fifo.sv
sv/gzip_header_parser.sv
bench/testbench.sv
